>>> src/psc_pkg.sv
// shared constants, types and helpers for the pressure sensor compensation unit
// no dependencies
`timescale 1ns / 1ps

package psc_pkg;

    localparam int DIV_WIDTH = 32;

    localparam logic [31:0] B6_OFFSET   = 32'd4000;
    localparam logic [31:0] B7_SCALE    = 32'd50000;
    localparam logic [31:0] P_COEF_SQ   = 32'd3038;
    localparam logic [31:0] P_COEF_LIN  = 32'hFFFF_E343;  // -7357
    localparam logic [31:0] P_OFFSET    = 32'd3791;
    localparam logic [31:0] B4_OFFSET   = 32'd32768;

    typedef enum logic [1:0] {
        REG_CAL_A = 2'd0,
        REG_CAL_B = 2'd1,
        REG_CAL_C = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] ac1;
        logic [31:0] ac2;
        logic [31:0] ac3;
        logic [31:0] ac4;
        logic [31:0] ac5;
        logic [31:0] ac6;
        logic [31:0] b1;
        logic [31:0] b2;
        logic [31:0] mc;
        logic [31:0] md;
    } t_cal;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sra32(input logic [31:0] v, input logic [4:0] n);
        return $unsigned($signed(v) >>> n);
    endfunction

endpackage

>>> src/psc_div_pipe.sv
// pipelined unsigned restoring divider, one quotient bit per stage
// depends on psc_pkg
`timescale 1ns / 1ps

module psc_div_pipe import psc_pkg::*; #(
    parameter int W      = DIV_WIDTH,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [W-1:0]      i_num,
    input  logic [W-1:0]      i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [W-1:0]      o_quot,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_v    [W];
    logic [W-1:0]      r_rem  [W];
    logic [W-1:0]      r_num  [W];
    logic [W-1:0]      r_den  [W];
    logic [SIDE_W-1:0] r_side [W];

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic              w_v;
        logic [W-1:0]      w_rem;
        logic [W-1:0]      w_num;
        logic [W-1:0]      w_den;
        logic [SIDE_W-1:0] w_side;
        logic [W:0]        w_trial;
        logic [W:0]        w_diff;
        logic [W-1:0]      n_rem;
        logic [W-1:0]      n_num;

        if (k == 0) begin : g_first
            assign w_v    = i_valid;
            assign w_rem  = '0;
            assign w_num  = i_num;
            assign w_den  = i_den;
            assign w_side = i_side;
        end else begin : g_next
            assign w_v    = r_v[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_num  = r_num[k-1];
            assign w_den  = r_den[k-1];
            assign w_side = r_side[k-1];
        end

        always_comb begin
            w_trial = {w_rem, w_num[W-1]};
            w_diff  = w_trial - {1'b0, w_den};
            if (!w_diff[W]) begin
                n_rem = w_diff[W-1:0];
                n_num = {w_num[W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[W-1:0];
                n_num = {w_num[W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_num[k]  <= n_num;
                r_den[k]  <= w_den;
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_v[W-1];
    assign o_quot  = r_num[W-1];
    assign o_side  = r_side[W-1];

endmodule

>>> src/pressure_sensor_compensation_unit.sv
// top level of the pressure sensor compensation unit
// depends on psc_pkg and psc_div_pipe
`timescale 1ns / 1ps

// usage
// - input channel: i_valid / o_ready carry one item: raw temperature, raw pressure
//   (right-aligned to the oversampling width) and the oversampling mode
// - output channel: o_valid / i_ready carry the temperature in tenths of a degree,
//   the pressure in pascals and a divide error flag (results zeroed on error)
// - calibration lives in three apb registers at byte addresses 0, 8 and 16,
//   64-bit data; write them only while no item is in flight
// - 74 register stages: one product stage, a 32-stage temperature divider,
//   six stages of products and sums, a 32-stage pressure divider, and three
//   stages of final correction ending in the output register
// - throughput is one item per cycle; the two bit-per-stage dividers set the depth
// - all stages advance together; when the output register holds an item the
//   receiver has not taken, the whole pipe freezes and o_ready drops, nothing is
//   lost or repeated, and o_ready returns as soon as the item is taken
// - a synchronous low reset clears all valid bits and the calibration registers

module pressure_sensor_compensation_unit import psc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input item channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [15:0]        i_raw_temperature,
    input  logic [18:0]        i_raw_pressure,
    input  logic [1:0]         i_oversampling,
    // result item channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_temperature,
    output logic signed [31:0] o_pressure,
    output logic               o_divide_error,
    // apb configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    localparam int DIV_W   = DIV_WIDTH;
    localparam int SIDE1_W = 32 + 19 + 2 + 1 + 1;
    localparam int SIDE2_W = 16 + 1 + 1;

    // ---------------- configuration ----------------
    logic [63:0] r_cal_a;
    logic [63:0] r_cal_b;
    logic [31:0] r_cal_c;
    t_reg_idx    w_idx;
    logic        w_wr;
    t_cal        cal;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:3]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_CAL_A: r_cal_a <= pwdata;
                REG_CAL_B: r_cal_b <= pwdata;
                REG_CAL_C: r_cal_c <= pwdata[31:0];
                default: ;  // unmapped slot, write ignored
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_CAL_A: prdata = r_cal_a;
            REG_CAL_B: prdata = r_cal_b;
            REG_CAL_C: prdata = {32'd0, r_cal_c};
            default:   prdata = '0;
        endcase
    end

    // unpack the ten calibration words, sign extended where signed
    always_comb begin
        cal.ac1 = sx16(r_cal_a[15:0]);
        cal.ac2 = sx16(r_cal_a[31:16]);
        cal.ac3 = sx16(r_cal_a[47:32]);
        cal.ac4 = {16'd0, r_cal_a[63:48]};
        cal.ac5 = {16'd0, r_cal_b[15:0]};
        cal.ac6 = {16'd0, r_cal_b[31:16]};
        cal.b1  = sx16(r_cal_b[47:32]);
        cal.b2  = sx16(r_cal_b[63:48]);
        cal.mc  = sx16(r_cal_c[15:0]);
        cal.md  = sx16(r_cal_c[31:16]);
    end

    // global advance: move unless a finished item waits at the output
    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // ---------------- stage 1: (ut - ac6) * ac5 ----------------
    logic        r1_v;
    logic [31:0] r1_prod;
    logic [18:0] r1_up;
    logic [1:0]  r1_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (en)  r1_v <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_prod <= ({16'd0, i_raw_temperature} - cal.ac6) * cal.ac5;
            r1_up   <= i_raw_pressure;
            r1_mode <= i_oversampling;
        end
    end

    // temperature divisor and signed operands folded to magnitudes
    logic [31:0] t_x1, t_div, t_num, t_an, t_ad;
    logic        t_neg, t_err;

    always_comb begin
        t_x1  = sra32(r1_prod, 5'd15);
        t_div = t_x1 + cal.md;
        t_num = cal.mc << 11;
        t_an  = t_num[31] ? (32'd0 - t_num) : t_num;
        t_ad  = t_div[31] ? (32'd0 - t_div) : t_div;
        t_neg = t_num[31] ^ t_div[31];
        t_err = (t_div == 32'd0);
    end

    logic               d1_v;
    logic [DIV_W-1:0]   d1_q;
    logic [SIDE1_W-1:0] d1_side;

    psc_div_pipe #(
        .W      (DIV_W),
        .SIDE_W (SIDE1_W)
    ) u_div_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r1_v),
        .i_num   (t_an[DIV_W-1:0]),
        .i_den   (t_ad[DIV_W-1:0]),
        .i_side  ({t_x1, r1_up, r1_mode, t_neg, t_err}),
        .o_valid (d1_v),
        .o_quot  (d1_q),
        .o_side  (d1_side)
    );

    // ---------------- stage 3: b5, temperature, b6 ----------------
    logic [31:0] s3_x1, s3_x2, s3_b5, s3_q, s3_t;
    logic [18:0] s3_up;
    logic [1:0]  s3_mode;
    logic        s3_neg, s3_err;

    always_comb begin
        {s3_x1, s3_up, s3_mode, s3_neg, s3_err} = d1_side;
        s3_q  = 32'(d1_q);
        s3_x2 = s3_neg ? (32'd0 - s3_q) : s3_q;
        s3_b5 = s3_x1 + s3_x2;
        s3_t  = sra32(s3_b5 + 32'd8, 5'd4);
    end

    logic        r3_v, r3_err;
    logic [15:0] r3_temp;
    logic [31:0] r3_b6;
    logic [18:0] r3_up;
    logic [1:0]  r3_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (en)  r3_v <= d1_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_temp <= s3_t[15:0];
            r3_b6   <= s3_b5 - B6_OFFSET;
            r3_up   <= s3_up;
            r3_mode <= s3_mode;
            r3_err  <= s3_err;
        end
    end

    // ---------------- stage 4: products of b6 ----------------
    logic        r4_v, r4_err;
    logic [15:0] r4_temp;
    logic [31:0] r4_b6sq, r4_ac2b6, r4_ac3b6;
    logic [18:0] r4_up;
    logic [1:0]  r4_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (en)  r4_v <= r3_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_b6sq  <= r3_b6 * r3_b6;
            r4_ac2b6 <= cal.ac2 * r3_b6;
            r4_ac3b6 <= cal.ac3 * r3_b6;
            r4_temp  <= r3_temp;
            r4_up    <= r3_up;
            r4_mode  <= r3_mode;
            r4_err   <= r3_err;
        end
    end

    // ---------------- stage 5: scale ----------------
    logic        r5_v, r5_err;
    logic [15:0] r5_temp;
    logic [31:0] r5_sq, r5_x2a, r5_x1c;
    logic [18:0] r5_up;
    logic [1:0]  r5_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (en)  r5_v <= r4_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_sq   <= sra32(r4_b6sq, 5'd12);
            r5_x2a  <= sra32(r4_ac2b6, 5'd11);
            r5_x1c  <= sra32(r4_ac3b6, 5'd13);
            r5_temp <= r4_temp;
            r5_up   <= r4_up;
            r5_mode <= r4_mode;
            r5_err  <= r4_err;
        end
    end

    // ---------------- stage 6: products of sq ----------------
    logic        r6_v, r6_err;
    logic [15:0] r6_temp;
    logic [31:0] r6_b2sq, r6_b1sq, r6_x2a, r6_x1c;
    logic [18:0] r6_up;
    logic [1:0]  r6_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else if (en)  r6_v <= r5_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_b2sq <= cal.b2 * r5_sq;
            r6_b1sq <= cal.b1 * r5_sq;
            r6_x2a  <= r5_x2a;
            r6_x1c  <= r5_x1c;
            r6_temp <= r5_temp;
            r6_up   <= r5_up;
            r6_mode <= r5_mode;
            r6_err  <= r5_err;
        end
    end

    // ---------------- stage 7: b3 and x3 ----------------
    logic [31:0] s7_x3, s7_sh, s7_x2b;

    always_comb begin
        s7_x3  = sra32(r6_b2sq, 5'd11) + r6_x2a;
        s7_sh  = ((cal.ac1 << 2) + s7_x3) << r6_mode;
        s7_x2b = sra32(r6_b1sq, 5'd16);
    end

    logic        r7_v, r7_err;
    logic [15:0] r7_temp;
    logic [31:0] r7_b3, r7_x3;
    logic [18:0] r7_up;
    logic [1:0]  r7_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_v <= 1'b0;
        else if (en)  r7_v <= r6_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_b3   <= sra32(s7_sh + 32'd2, 5'd2);
            r7_x3   <= sra32(r6_x1c + s7_x2b + 32'd2, 5'd2);
            r7_temp <= r6_temp;
            r7_up   <= r6_up;
            r7_mode <= r6_mode;
            r7_err  <= r6_err;
        end
    end

    // ---------------- stage 8: b4 and b7 products ----------------
    logic        r8_v, r8_err;
    logic [15:0] r8_temp;
    logic [31:0] r8_b4p, r8_b7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r8_v <= 1'b0;
        else if (en)  r8_v <= r7_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_b4p  <= cal.ac4 * (r7_x3 + B4_OFFSET);
            r8_b7   <= ({13'd0, r7_up} - r7_b3) * (B7_SCALE >> r7_mode);
            r8_temp <= r7_temp;
            r8_err  <= r7_err;
        end
    end

    // pressure dividend: pre-double when b7 is below the sign bit
    logic [31:0] s8_b4, s8_num;
    logic        s8_post, s8_err;

    always_comb begin
        s8_b4   = r8_b4p >> 15;
        s8_post = r8_b7[31];
        s8_num  = s8_post ? r8_b7 : (r8_b7 << 1);
        s8_err  = r8_err || (s8_b4 == 32'd0);
    end

    logic               d2_v;
    logic [DIV_W-1:0]   d2_q;
    logic [SIDE2_W-1:0] d2_side;

    psc_div_pipe #(
        .W      (DIV_W),
        .SIDE_W (SIDE2_W)
    ) u_div_press (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r8_v),
        .i_num   (s8_num[DIV_W-1:0]),
        .i_den   (s8_b4[DIV_W-1:0]),
        .i_side  ({r8_temp, s8_post, s8_err}),
        .o_valid (d2_v),
        .o_quot  (d2_q),
        .o_side  (d2_side)
    );

    // ---------------- stage 9: p and its products ----------------
    logic [15:0] s9_temp;
    logic        s9_post, s9_err;
    logic [31:0] s9_p, s9_ps;

    always_comb begin
        {s9_temp, s9_post, s9_err} = d2_side;
        s9_p  = s9_post ? (32'(d2_q) << 1) : 32'(d2_q);
        s9_ps = sra32(s9_p, 5'd8);
    end

    logic        r9_v, r9_err;
    logic [15:0] r9_temp;
    logic [31:0] r9_p, r9_psq, r9_lin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r9_v <= 1'b0;
        else if (en)  r9_v <= d2_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_p    <= s9_p;
            r9_psq  <= s9_ps * s9_ps;
            r9_lin  <= P_COEF_LIN * s9_p;
            r9_temp <= s9_temp;
            r9_err  <= s9_err;
        end
    end

    // ---------------- stage 10: square term coefficient ----------------
    logic        r10_v, r10_err;
    logic [15:0] r10_temp;
    logic [31:0] r10_p, r10_x1, r10_x2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r10_v <= 1'b0;
        else if (en)  r10_v <= r9_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_x1   <= r9_psq * P_COEF_SQ;
            r10_x2   <= sra32(r9_lin, 5'd16);
            r10_p    <= r9_p;
            r10_temp <= r9_temp;
            r10_err  <= r9_err;
        end
    end

    // ---------------- output register ----------------
    logic [31:0] s11_p;

    always_comb begin
        s11_p = r10_p + sra32(sra32(r10_x1, 5'd16) + r10_x2 + P_OFFSET, 5'd4);
    end

    logic        r_out_v;
    logic [15:0] r_out_temp;
    logic [31:0] r_out_p;
    logic        r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_v <= 1'b0;
        else if (en)  r_out_v <= r10_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_temp <= r10_err ? 16'd0 : r10_temp;
            r_out_p    <= r10_err ? 32'd0 : s11_p;
            r_out_err  <= r10_err;
        end
    end

    assign o_valid        = r_out_v;
    assign o_temperature  = $signed(r_out_temp);
    assign o_pressure     = $signed(r_out_p);
    assign o_divide_error = r_out_err;

endmodule

>>> src/psc_checker.sv
// port-level checks for the pressure sensor compensation unit, bound to the top
// depends on pressure_sensor_compensation_unit
`timescale 1ns / 1ps

module psc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [15:0] o_temperature,
    input logic signed [31:0] o_pressure,
    input logic               o_divide_error
);

    // a waiting result blocks intake
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready) else $error("intake open while stalled");

    // an empty output never blocks intake
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready) else $error("intake closed with empty output");

    // error results carry zeros
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_error) |-> (o_temperature == 16'sd0 && o_pressure == 32'sd0))
        else $error("error result not zeroed");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_pressure) && $stable(o_temperature)))
        else $error("stalled result changed");

endmodule

bind pressure_sensor_compensation_unit psc_checker u_psc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_temperature  (o_temperature),
    .o_pressure     (o_pressure),
    .o_divide_error (o_divide_error)
);

>>> bench/pressure_sensor_compensation_unit_tb.sv
// testbench for the pressure sensor compensation unit: directed table then random items
// depends on psc_pkg and the pressure_sensor_compensation_unit rtl
`timescale 1ns / 1ps

module pressure_sensor_compensation_unit_tb;
    import psc_pkg::*;

    localparam int LATENCY   = 74;
    localparam int N_RANDOM  = 1250;
    localparam int WATCHDOG  = 20000;
    localparam int N_TABLE   = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [15:0] i_raw_temperature = '0;
    logic [18:0] i_raw_pressure = '0;
    logic [1:0]  i_oversampling = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic signed [15:0] o_temperature;
    logic signed [31:0] o_pressure;
    logic        o_divide_error;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    // one compensated result
    typedef struct packed {
        logic [15:0] temperature;
        logic [31:0] pressure;
        logic        divide_error;
    } comp_result_t;

    // one directed row; has_fixed marks a result typed in by hand
    typedef struct {
        logic [15:0]  ut;
        logic [18:0]  up;
        logic [1:0]   oss;
        bit           has_fixed;
        comp_result_t fixed;
    } stim_row_t;

    comp_result_t pending_results[$];
    logic [63:0]  cal_a, cal_b, cal_c;
    bit           failed = 1'b0;
    int           idle_cycles = 0;
    int           rcv_stall_max = 3;

    pressure_sensor_compensation_unit uut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor: 32-bit wrapping integer compensation
    // ------------------------------------------------------------------
    function automatic logic [31:0] asr(input logic [31:0] v, input int n);
        return $unsigned($signed(v) >>> n);
    endfunction

    // signed divide truncating toward zero, divisor nonzero
    function automatic logic [31:0] div_trunc(input logic [31:0] n, input logic [31:0] d);
        logic [31:0] an, ad, q;
        an = n[31] ? -n : n;
        ad = d[31] ? -d : d;
        q  = an / ad;
        return (n[31] != d[31]) ? -q : q;
    endfunction

    function automatic logic [31:0] ext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic comp_result_t compensate(input logic [15:0] ut_in,
                                                input logic [18:0] up_in,
                                                input logic [1:0] oss);
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] x1, x2, x3, dv, b5, b6, sq, b3, b4, b7, p, t;
        comp_result_t r;
        r = '0;
        ac1 = ext16(cal_a[15:0]);
        ac2 = ext16(cal_a[31:16]);
        ac3 = ext16(cal_a[47:32]);
        ac4 = {16'd0, cal_a[63:48]};
        ac5 = {16'd0, cal_b[15:0]};
        ac6 = {16'd0, cal_b[31:16]};
        b1  = ext16(cal_b[47:32]);
        b2  = ext16(cal_b[63:48]);
        mc  = ext16(cal_c[15:0]);
        md  = ext16(cal_c[31:16]);

        // temperature stage
        x1 = asr(({16'd0, ut_in} - ac6) * ac5, 15);
        dv = x1 + md;
        if (dv == 0) begin
            r.divide_error = 1'b1;
            return r;
        end
        x2 = div_trunc(mc << 11, dv);
        b5 = x1 + x2;
        t  = asr(b5 + 32'd8, 4);

        // pressure stage
        b6 = b5 - 32'd4000;
        sq = asr(b6 * b6, 12);
        x1 = asr(b2 * sq, 11);
        x2 = asr(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = asr((((ac1 << 2) + x3) << oss) + 32'd2, 2);
        x1 = asr(ac3 * b6, 13);
        x2 = asr(b1 * sq, 16);
        x3 = asr(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        if (b4 == 0) begin
            r.divide_error = 1'b1;
            return r;
        end
        b7 = ({13'd0, up_in} - b3) * (32'd50000 >> oss);
        if (!b7[31])
            p = (b7 << 1) / b4;
        else
            p = (b7 / b4) << 1;
        x1 = asr(p, 8) * asr(p, 8);
        x1 = asr(x1 * 32'd3038, 16);
        x2 = asr(32'hFFFF_E343 * p, 16);
        p  = p + asr(x1 + x2 + 32'd3791, 4);

        r.temperature = t[15:0];
        r.pressure    = p;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // apb register write, block idle
    // ------------------------------------------------------------------
    task automatic write_cal(input t_reg_idx idx, input logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx) << 3;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CAL_A: cal_a = value;
            REG_CAL_B: cal_b = value;
            default:   cal_c = {32'd0, value[31:0]};
        endcase
    endtask

    task automatic load_cal(input logic [63:0] a, input logic [63:0] b, input logic [63:0] c);
        write_cal(REG_CAL_A, a);
        write_cal(REG_CAL_B, b);
        write_cal(REG_CAL_C, c);
    endtask

    // wait for the pipe to drain before touching calibration
    task automatic drain_pipe();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (pending_results.size() != 0 && guard < WATCHDOG * 4) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // sender: one item, valid held until accepted
    // ------------------------------------------------------------------
    task automatic send_item(input logic [15:0] ut_in, input logic [18:0] up_in,
                             input logic [1:0] oss, input bit has_fixed,
                             input comp_result_t fixed);
        comp_result_t want;
        int gap;
        // about half none, most others short, a few long
        gap = ($urandom_range(0, 9) < 5) ? 0 :
              (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3));
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_raw_temperature <= ut_in;
        i_raw_pressure    <= up_in;
        i_oversampling    <= oss;
        want = has_fixed ? fixed : compensate(ut_in, up_in, oss);
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(want);
    endtask

    // random well-formed reading around realistic values, with some raw noise
    task automatic send_random();
        logic [15:0] ut_in;
        logic [18:0] up_in;
        logic [1:0]  oss;
        oss = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 3) != 0) begin
            ut_in = 16'($urandom_range(20000, 32000));
            up_in = 19'($urandom_range(20000, 45000) << oss);
        end else begin
            ut_in = 16'($urandom);
            up_in = 19'($urandom);
        end
        send_item(ut_in, up_in, oss, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // receiver with random stalls, and result checking
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 99) < 8)
                i_ready <= 1'b0;
            else if ($urandom_range(0, 99) < 60 || rcv_stall_max == 0)
                i_ready <= 1'b1;
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result item with no expectation");
                    failed <= 1'b1;
                end else begin
                    automatic comp_result_t want = pending_results.pop_front();
                    if (o_temperature !== want.temperature) begin
                        $error("temperature expected %0d got %0d",
                               $signed(want.temperature), o_temperature);
                        failed <= 1'b1;
                    end
                    if (o_pressure !== want.pressure) begin
                        $error("pressure expected %0d got %0d",
                               $signed(want.pressure), o_pressure);
                        failed <= 1'b1;
                    end
                    if (o_divide_error !== want.divide_error) begin
                        $error("divide_error expected %0b got %0b",
                               want.divide_error, o_divide_error);
                        failed <= 1'b1;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("FAIL pressure_sensor_compensation_unit");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    // datasheet example calibration
    localparam logic [63:0] CAL_A_DS = {16'd32741, 16'hC7D1, 16'hFFB8, 16'h0198};
    localparam logic [63:0] CAL_B_DS = {16'd4, 16'd6190, 16'd23153, 16'd32757};
    localparam logic [63:0] CAL_C_DS = {32'd0, 16'd2868, 16'hDDF9};

    stim_row_t stim_table[N_TABLE];

    initial begin
        logic [63:0] ra, rb, rc;
        int phase;
        cal_a = '0;
        cal_b = '0;
        cal_c = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // after reset md is zero and so is x1: temperature divisor zero
        send_item(16'd0, 19'd0, 2'd0, 1'b1, '{16'd0, 32'd0, 1'b1});
        send_item(16'hFFFF, 19'h7FFFF, 2'd3, 1'b1, '{16'd0, 32'd0, 1'b1});
        drain_pipe();

        // md nonzero but ac4 zero: pressure divisor zero
        load_cal(64'd0, 64'd0, {32'd0, 16'd1, 16'd0});
        send_item(16'd1234, 19'd5, 2'd1, 1'b1, '{16'd0, 32'd0, 1'b1});
        drain_pipe();

        // datasheet values, field extremes and every mode
        load_cal(CAL_A_DS, CAL_B_DS, CAL_C_DS);
        // datasheet example point: 15.0 degrees, 69964 pa
        stim_table[0] = '{16'd27898, 19'd23843, 2'd0, 1'b1, '{16'd150, 32'd69964, 1'b0}};
        for (int k = 1; k < N_TABLE; k++) begin
            stim_table[k].has_fixed = 1'b0;
            stim_table[k].fixed     = '0;
            stim_table[k].oss       = 2'(k);
            stim_table[k].ut        = (k % 3 == 0) ? 16'h0000 :
                                      (k % 3 == 1) ? 16'hFFFF : 16'(27000 + k * 100);
            stim_table[k].up        = (k % 4 == 0) ? 19'h00000 :
                                      (k % 4 == 1) ? 19'h7FFFF : 19'(23000 << (k % 4));
        end
        for (int k = 0; k < N_TABLE; k++)
            send_item(stim_table[k].ut, stim_table[k].up, stim_table[k].oss,
                      stim_table[k].has_fixed, stim_table[k].fixed);
        drain_pipe();

        // all-ones calibration: wrapping and odd signs
        load_cal('1, '1, 64'hFFFF_FFFF);
        repeat (4) send_random();
        drain_pipe();

        // random phases: datasheet-like with jitter, and fully random words
        for (phase = 0; phase < 5; phase++) begin
            if (phase % 2 == 0) begin
                ra = CAL_A_DS ^ {48'd0, 16'($urandom_range(0, 255))};
                rb = CAL_B_DS ^ {32'd0, 16'($urandom_range(0, 255)), 16'd0};
                rc = CAL_C_DS ^ {32'd0, 16'($urandom_range(0, 63)), 16'd0};
            end else begin
                ra = {$urandom, $urandom};
                rb = {$urandom, $urandom};
                rc = {32'd0, $urandom};
            end
            load_cal(ra, rb, rc);
            repeat (N_RANDOM / 5) send_random();
            drain_pipe();
        end
        drain_pipe();

        if (!failed && pending_results.size() == 0) begin
            $display("PASS pressure_sensor_compensation_unit");
        end else begin
            if (pending_results.size() != 0)
                $error("%0d result items never arrived", pending_results.size());
            $display("FAIL pressure_sensor_compensation_unit");
        end
        $finish;
    end

endmodule
